// ----- sv/priority_scheduler_with_sleep_timers_unit_defines.svh -----
// Assertion macros for the task scheduler.
`ifndef PRIORITY_SCHEDULER_WITH_SLEEP_TIMERS_UNIT_DEFINES_SVH
`define PRIORITY_SCHEDULER_WITH_SLEEP_TIMERS_UNIT_DEFINES_SVH
// Implication checked on every edge outside reset.
`define PST_ASSERT_IMP(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define PST_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

// ----- sv/pst_pkg.sv -----
// Package with constants and types shared by the task scheduler.
package pst_pkg;
  localparam int NUM_SLOTS_DEF = 16;
  localparam int COUNT_WIDTH_DEF = 32;
  localparam logic [2:0] CMD_TICK = 3'd0;
  localparam logic [2:0] CMD_CREATE = 3'd1;
  localparam logic [2:0] CMD_SLEEP = 3'd2;
  localparam logic [2:0] CMD_SETPRI = 3'd3;
  localparam logic [2:0] CMD_TERM = 3'd4;
  localparam logic [2:0] CMD_RESCHED = 3'd5;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BADPRI = 2'd2;
  localparam logic [1:0] ST_NORUN = 2'd3;
  localparam logic [1:0] REG_MINPRI = 2'd0;
  localparam logic [1:0] REG_MAXPRI = 2'd1;
  localparam logic [1:0] REG_TPS = 2'd2;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_TICK = 6'b000100,
    S_EXEC = 6'b001000,
    S_PICK = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  // Control shared by every cell of the chain in one cycle.
  typedef struct packed {
    logic tick_dec;
    logic shift_in;
  } cell_ctl_t;
endpackage

// ----- sv/pst_cell.sv -----
// One cell of the sleep chain: a countdown and its slot, shifting to the neighbour.
module pst_cell #(
  parameter int SW = 4,
  parameter int CW = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  pst_pkg::cell_ctl_t ctl,
  input  logic              prev_valid,
  input  logic [SW-1:0]     prev_slot,
  input  logic [CW-1:0]     prev_count,
  input  logic              load,
  input  logic [SW-1:0]     load_slot,
  input  logic [CW-1:0]     load_count,
  output logic              valid,
  output logic [SW-1:0]     slot,
  output logic [CW-1:0]     count
);
  logic [CW-1:0] dec;

  assign dec = (count != '0) ? count - CW'(1) : count;

  // A load wins over a shift, which passes the contents on; else tick_dec counts a valid cell down.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
      slot <= load_slot;
      count <= load_count;
    end else if (ctl.shift_in) begin
      valid <= prev_valid;
      slot <= prev_slot;
      count <= prev_count;
    end else if (ctl.tick_dec && valid) begin
      count <= dec;
    end
  end
endmodule

// ----- sv/priority_scheduler_with_sleep_timers_unit.sv -----
// Top level of the priority task scheduler with tick sleep timers.
// Usage: pulse start with command, sleep_seconds and new_priority while busy is low;
// the transfer is taken at that edge and busy rises. One result appears on
// status, created_id, running_valid, running_id, switched, preempt_request and
// woken_count for one cycle, marked by done. The receiver cannot stall.
// Every command but tick first looks for the running task in the ready list in
// S_MUL, one entry per cycle, then executes in S_EXEC, followed by S_DONE for a
// create that finds a free slot. A tick shifts the sleep chain once per sleeping task.
// If no task runs afterwards, S_PICK scans the ready list for the task to run;
// otherwise it ends without a scan. A sleep with a full ready list is the worst case.
// done rises as busy falls, and the next command is taken from that cycle on.
// The sleep list is a chain of cells that rotates once per tick: each cell is
// counted down when it reaches the head, and expired tasks leave the chain.
// The user writes registers by cfg_we, cfg_index, cfg_data at an edge while idle;
// the block does not enforce it. Reset empties all lists and the task table, sets
// min_priority 0, max_priority 15, ticks_per_second 100, and needs no clearing pass.
module priority_scheduler_with_sleep_timers_unit #(
  parameter int NUM_SLOTS = pst_pkg::NUM_SLOTS_DEF,
  parameter int COUNT_WIDTH = pst_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command,
  input  logic [15:0] sleep_seconds,
  input  logic [7:0]  new_priority,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        done,
  output logic [1:0]  status,
  output logic [3:0]  created_id,
  output logic        running_valid,
  output logic [3:0]  running_id,
  output logic        switched,
  output logic        preempt_request,
  output logic [4:0]  woken_count
);
  `include "priority_scheduler_with_sleep_timers_unit_defines.svh"

  localparam int SW = $clog2(NUM_SLOTS);
  localparam int LW = $clog2(NUM_SLOTS + 1);
  localparam int CW = COUNT_WIDTH;

  pst_pkg::state_t state;
  logic [7:0]  min_priority, max_priority;
  logic [15:0] ticks_per_second;
  logic [2:0]  cmd;
  logic [15:0] secs;
  logic [7:0]  newp;

  logic [NUM_SLOTS-1:0] slot_used;
  logic [7:0]  slot_priority [NUM_SLOTS];
  logic [SW-1:0] ready_order [NUM_SLOTS];
  logic [LW-1:0] ready_length;
  logic [SW-1:0] running_slot;
  logic running_present, reschedule_pending;
  logic prev_present;
  logic [SW-1:0] prev_slot;
  logic run_ok;

  logic [31:0] product;
  logic [CW-1:0] sleep_cnt;

  logic [LW-1:0] idx;
  logic [7:0]  best;
  logic [SW-1:0] best_slot;
  logic [LW-1:0] rem_pos;
  logic          rem_found;
  logic [4:0]  woken;
  logic        preempt;
  logic [1:0]  st;
  logic [SW-1:0] created;
  logic [SW-1:0] free_slot;

  // Sleep chain.
  pst_pkg::cell_ctl_t ctl;
  logic [NUM_SLOTS-1:0] c_valid;
  logic [SW-1:0] c_slot [NUM_SLOTS];
  logic [CW-1:0] c_count [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] c_load;
  logic [SW-1:0] load_slot;
  logic [CW-1:0] load_count;
  logic [LW-1:0] sleep_length;
  logic [LW-1:0] tick_cnt;
  logic head_expire;
  logic head_keep;
  logic [SW-1:0] head_slot;
  logic [CW-1:0] head_dec;

  assign head_slot = c_slot[0];
  assign head_dec = (c_count[0] != '0) ? c_count[0] - CW'(1) : c_count[0];
  assign head_expire = c_valid[0] && (head_dec == '0);
  assign head_keep = c_valid[0] && !head_expire;

  genvar g;
  generate
    for (g = 0; g < NUM_SLOTS; g++) begin : g_cell
      logic pv;
      logic [SW-1:0] ps;
      logic [CW-1:0] pc;
      logic wrap;
      // The current tail cell takes the head back unless the head has expired.
      assign wrap = (sleep_length == LW'(g + 1));
      if (g == NUM_SLOTS - 1) begin : g_last
        assign pv = wrap && head_keep;
        assign ps = c_slot[0];
        assign pc = head_dec;
      end else begin : g_mid
        assign pv = wrap ? head_keep : c_valid[g+1];
        assign ps = wrap ? c_slot[0] : c_slot[g+1];
        assign pc = wrap ? head_dec : c_count[g+1];
      end
      pst_cell #(.SW(SW), .CW(CW)) u_cell (
        .clk(clk), .rst(rst), .ctl(ctl),
        .prev_valid(pv), .prev_slot(ps), .prev_count(pc),
        .load(c_load[g]), .load_slot(load_slot), .load_count(load_count),
        .valid(c_valid[g]), .slot(c_slot[g]), .count(c_count[g])
      );
    end
  endgenerate

  assign busy = (state != pst_pkg::S_IDLE);
  assign run_ok = running_present;
  assign ctl.tick_dec = 1'b0;
  assign ctl.shift_in = (state == pst_pkg::S_TICK) && (tick_cnt != '0);
  assign load_slot = running_slot;
  assign load_count = sleep_cnt;

  always_comb begin
    c_load = '0;
    if (state == pst_pkg::S_EXEC && cmd == pst_pkg::CMD_SLEEP && run_ok && rem_found) begin
      c_load[sleep_length[SW-1:0]] = 1'b1;
    end
  end

  always_comb begin
    free_slot = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (!slot_used[i]) begin
        free_slot = SW'(i);
      end
    end
  end

  // Saturation of the sleep count, which is also held at least 1.
  always_comb begin
    if (CW < 32 && (product >> CW) != '0) begin
      sleep_cnt = '1;
    end else begin
      sleep_cnt = CW'(product);
    end
    if (sleep_cnt == '0) begin
      sleep_cnt = CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_priority <= 8'd0;
      max_priority <= 8'd15;
      ticks_per_second <= 16'd100;
    end else if (cfg_we) begin
      case (cfg_index)
        pst_pkg::REG_MINPRI: min_priority <= cfg_data[7:0];
        pst_pkg::REG_MAXPRI: max_priority <= cfg_data[7:0];
        pst_pkg::REG_TPS:    ticks_per_second <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pst_pkg::S_IDLE;
      slot_used <= '0;
      ready_length <= '0;
      sleep_length <= '0;
      running_slot <= '0;
      running_present <= 1'b0;
      reschedule_pending <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= (state == pst_pkg::S_PICK) && (running_present || ready_length == '0);
      case (state)
        pst_pkg::S_IDLE: begin
          if (start) begin
            cmd <= command;
            secs <= sleep_seconds;
            newp <= new_priority;
            prev_present <= running_present;
            prev_slot <= running_slot;
            woken <= '0;
            preempt <= 1'b0;
            st <= pst_pkg::ST_OK;
            created <= '0;
            idx <= '0;
            rem_found <= 1'b0;
            rem_pos <= '0;
            tick_cnt <= sleep_length;
            state <= (command == pst_pkg::CMD_TICK) ? pst_pkg::S_TICK : pst_pkg::S_MUL;
          end
        end
        pst_pkg::S_MUL: begin
          // Multiply and locate the running task in the ready list, one entry a cycle.
          product <= 32'(secs) * 32'(ticks_per_second);
          if (idx < ready_length && !rem_found) begin
            if (ready_order[idx[SW-1:0]] == running_slot) begin
              rem_found <= 1'b1;
              rem_pos <= idx;
            end
            idx <= idx + LW'(1);
          end else begin
            state <= pst_pkg::S_EXEC;
          end
        end
        pst_pkg::S_TICK: begin
          if (tick_cnt == '0) begin
            state <= pst_pkg::S_PICK;
            idx <= '0;
          end else begin
            tick_cnt <= tick_cnt - LW'(1);
            if (head_expire) begin
              sleep_length <= sleep_length - LW'(1);
              ready_order[ready_length[SW-1:0]] <= head_slot;
              ready_length <= ready_length + LW'(1);
              woken <= woken + 5'd1;
              if (run_ok && slot_priority[running_slot] < slot_priority[head_slot]) begin
                reschedule_pending <= 1'b1;
                preempt <= 1'b1;
              end
            end
          end
        end
        pst_pkg::S_EXEC: begin
          idx <= '0;
          state <= (cmd == pst_pkg::CMD_CREATE && !(&slot_used)) ?
                   pst_pkg::S_DONE : pst_pkg::S_PICK;
          if (cmd == pst_pkg::CMD_CREATE) begin
            if (&slot_used) begin
              st <= pst_pkg::ST_FULL;
            end else begin
              created <= free_slot;
            end
          end else if ((cmd == pst_pkg::CMD_SLEEP || cmd == pst_pkg::CMD_SETPRI ||
                        cmd == pst_pkg::CMD_TERM) && !run_ok) begin
            st <= pst_pkg::ST_NORUN;
          end else if (cmd == pst_pkg::CMD_SLEEP || cmd == pst_pkg::CMD_TERM) begin
            for (int i = 0; i < NUM_SLOTS - 1; i++) begin
              if (LW'(i) >= rem_pos && LW'(i + 1) < ready_length) begin
                ready_order[i] <= ready_order[i+1];
              end
            end
            if (rem_found) begin
              ready_length <= ready_length - LW'(1);
            end
            if (cmd == pst_pkg::CMD_SLEEP) begin
              if (rem_found) begin
                sleep_length <= sleep_length + LW'(1);
              end
              reschedule_pending <= 1'b0;
            end else begin
              slot_used[running_slot] <= 1'b0;
            end
            running_present <= 1'b0;
          end else if (cmd == pst_pkg::CMD_SETPRI) begin
            if (newp < min_priority || newp > max_priority) begin
              st <= pst_pkg::ST_BADPRI;
            end else begin
              if (newp < slot_priority[running_slot]) begin
                reschedule_pending <= 1'b1;
                preempt <= 1'b1;
              end
              slot_priority[running_slot] <= newp;
            end
          end else if (cmd == pst_pkg::CMD_RESCHED) begin
            if (reschedule_pending) begin
              reschedule_pending <= 1'b0;
              running_present <= 1'b0;
            end
          end
        end
        pst_pkg::S_DONE: begin
          // Second half of create: table entry and ready tail.
          slot_used[created] <= 1'b1;
          slot_priority[created] <= run_ok ? slot_priority[running_slot] : min_priority;
          ready_order[ready_length[SW-1:0]] <= created;
          ready_length <= ready_length + LW'(1);
          idx <= '0;
          state <= pst_pkg::S_PICK;
        end
        pst_pkg::S_PICK: begin
          // Scan the ready list only when no task runs.
          if (running_present || ready_length == '0) begin
            state <= pst_pkg::S_IDLE;
          end else if (idx == '0) begin
            best <= (slot_priority[ready_order[0]] > min_priority) ?
                    slot_priority[ready_order[0]] : min_priority;
            best_slot <= ready_order[0];
            idx <= LW'(1);
            if (slot_priority[ready_order[0]] == max_priority) begin
              running_slot <= ready_order[0];
              running_present <= 1'b1;
            end
          end else if (idx < ready_length) begin
            idx <= idx + LW'(1);
            if (slot_priority[ready_order[idx[SW-1:0]]] == max_priority) begin
              running_slot <= ready_order[idx[SW-1:0]];
              running_present <= 1'b1;
            end else if (slot_priority[ready_order[idx[SW-1:0]]] > best) begin
              best <= slot_priority[ready_order[idx[SW-1:0]]];
              best_slot <= ready_order[idx[SW-1:0]];
            end
          end else begin
            running_slot <= best_slot;
            running_present <= 1'b1;
          end
        end
        default: state <= pst_pkg::S_IDLE;
      endcase
    end
  end

  assign status = st;
  assign created_id = 4'(created);
  assign running_valid = running_present;
  assign running_id = running_present ? 4'(running_slot) : 4'd0;
  assign switched = (prev_present != running_present) ||
                    (running_present && prev_slot != running_slot);
  assign preempt_request = preempt;
  assign woken_count = woken;

  `PST_ASSERT_IMP(a_len, clk, rst, 1'b1, (ready_length + sleep_length) <= LW'(NUM_SLOTS))
  `PST_ASSERT_IMP(a_done_idle, clk, rst, done, state == pst_pkg::S_IDLE)
  `PST_ASSERT_IMP(a_run_ready, clk, rst, done && running_present, ready_length != '0)
endmodule

// ----- bench/tb_priority_scheduler_with_sleep_timers_unit.sv -----
// Self-checking testbench for the priority task scheduler with tick sleep timers.
module tb_priority_scheduler_with_sleep_timers_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 16;
  localparam int DRAIN_CYCLES = 40;
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;
  localparam int RDY = 0;
  localparam int SLP = 1;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] created_id;
    logic       running_valid;
    logic [3:0] running_id;
    logic       switched;
    logic       preempt_request;
    logic [4:0] woken_count;
  } sched_result_t;

  typedef struct {
    logic [2:0]    cmd;
    logic [15:0]   secs;
    logic [7:0]    prio;
    bit            typed;
    sched_result_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [2:0] command = '0;
  logic [15:0] sleep_seconds = '0;
  logic [7:0] new_priority = '0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic done;
  logic [1:0] status;
  logic [3:0] created_id;
  logic running_valid;
  logic [3:0] running_id;
  logic switched;
  logic preempt_request;
  logic [4:0] woken_count;

  priority_scheduler_with_sleep_timers_unit u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .command(command),
    .sleep_seconds(sleep_seconds), .new_priority(new_priority), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done), .status(status),
    .created_id(created_id), .running_valid(running_valid), .running_id(running_id),
    .switched(switched), .preempt_request(preempt_request), .woken_count(woken_count)
  );

  always #5 clk = ~clk;

  logic [7:0] m_minpri, m_maxpri;
  logic [15:0] m_tps;
  bit m_used [SLOTS];
  logic [7:0] m_pri [SLOTS];
  logic [31:0] m_count [SLOTS];
  int m_list [2][SLOTS];
  int m_len [2];
  int m_run;
  bit m_present, m_pending;

  sched_result_t expected_q[$];
  dir_row_t dir_rows[$];
  int mismatches = 0;
  int idle_pct = 0;

  function automatic void list_add(int which, int s);
    if (m_len[which] < SLOTS) begin
      m_list[which][m_len[which]] = s;
      m_len[which]++;
    end
  endfunction

  function automatic void list_drop(int which, int s);
    for (int i = 0; i < m_len[which]; i++) begin
      if (m_list[which][i] == s) begin
        for (int j = i; j + 1 < m_len[which]; j++) m_list[which][j] = m_list[which][j + 1];
        m_len[which]--;
        return;
      end
    end
  endfunction

  function automatic void choose_running();
    logic [7:0] best;
    int sel;
    if (m_len[RDY] == 0) begin
      m_present = 1'b0;
      return;
    end
    best = m_minpri;
    sel = m_list[RDY][0];
    for (int i = 0; i < m_len[RDY]; i++) begin
      if (m_pri[m_list[RDY][i]] == m_maxpri) begin
        sel = m_list[RDY][i];
        break;
      end
      if (m_pri[m_list[RDY][i]] > best) begin
        best = m_pri[m_list[RDY][i]];
        sel = m_list[RDY][i];
      end
    end
    m_run = sel;
    m_present = 1'b1;
  endfunction

  function automatic sched_result_t schedule_step(logic [2:0] cmd, logic [15:0] secs,
                                                  logic [7:0] newp);
    sched_result_t r;
    bit was_present, run_ok;
    int was_run, s, n;
    int snap [SLOTS];
    logic [63:0] cnt;
    r = '0;
    was_present = m_present;
    was_run = m_run;
    run_ok = m_present;
    if (cmd == pst_pkg::CMD_TICK) begin
      n = m_len[SLP];
      for (int i = 0; i < SLOTS; i++) snap[i] = m_list[SLP][i];
      for (int i = 0; i < n; i++) begin
        s = snap[i];
        if (m_count[s] > 0) m_count[s]--;
        if (m_count[s] == 0) begin
          list_drop(SLP, s);
          list_add(RDY, s);
          r.woken_count++;
          if (run_ok && m_pri[m_run] < m_pri[s]) begin
            m_pending = 1'b1;
            r.preempt_request = 1'b1;
          end
        end
      end
    end else if (cmd == pst_pkg::CMD_CREATE) begin
      s = 0;
      while (s < SLOTS && m_used[s]) s++;
      if (s >= SLOTS) begin
        r.status = pst_pkg::ST_FULL;
      end else begin
        m_used[s] = 1'b1;
        m_pri[s] = run_ok ? m_pri[m_run] : m_minpri;
        list_add(RDY, s);
        r.created_id = s[3:0];
      end
    end else if ((cmd == pst_pkg::CMD_SLEEP || cmd == pst_pkg::CMD_SETPRI ||
                  cmd == pst_pkg::CMD_TERM) && !run_ok) begin
      r.status = pst_pkg::ST_NORUN;
    end else if (cmd == pst_pkg::CMD_SLEEP) begin
      cnt = 64'(secs) * 64'(m_tps);
      if (cnt > 64'hFFFF_FFFF) cnt = 64'hFFFF_FFFF;
      if (cnt == 0) cnt = 1;
      m_count[m_run] = cnt[31:0];
      list_drop(RDY, m_run);
      list_add(SLP, m_run);
      choose_running();
      m_pending = 1'b0;
    end else if (cmd == pst_pkg::CMD_SETPRI) begin
      if (newp < m_minpri || newp > m_maxpri) begin
        r.status = pst_pkg::ST_BADPRI;
      end else begin
        if (newp < m_pri[m_run]) begin
          m_pending = 1'b1;
          r.preempt_request = 1'b1;
        end
        m_pri[m_run] = newp;
      end
    end else if (cmd == pst_pkg::CMD_TERM) begin
      list_drop(RDY, m_run);
      m_used[m_run] = 1'b0;
      choose_running();
    end else if (cmd == pst_pkg::CMD_RESCHED) begin
      if (m_pending) begin
        m_pending = 1'b0;
        if (m_len[RDY] > 0) choose_running();
      end
    end
    if (!m_present && m_len[RDY] > 0) choose_running();
    r.running_valid = m_present;
    r.running_id = m_present ? m_run[3:0] : 4'd0;
    r.switched = (was_present != m_present) || (m_present && was_run != m_run);
    return r;
  endfunction

  always @(posedge clk) begin
    sched_result_t want, got;
    if (!rst && done) begin
      got = '{status, created_id, running_valid, running_id, switched, preempt_request,
              woken_count};
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result %p", got);
      end else begin
        want = expected_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  task automatic issue(logic [2:0] cmd, logic [15:0] secs, logic [7:0] prio,
                       bit typed, sched_result_t typed_res);
    sched_result_t r;
    start <= 1'b1;
    command <= cmd;
    sleep_seconds <= secs;
    new_priority <= prio;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = schedule_step(cmd, secs, prio);
    expected_q.push_back(typed ? typed_res : r);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      pst_pkg::REG_MINPRI: m_minpri = val[7:0];
      pst_pkg::REG_MAXPRI: m_maxpri = val[7:0];
      default:             m_tps = val;
    endcase
  endtask

  task automatic add_row(logic [2:0] cmd, logic [15:0] secs, logic [7:0] prio, bit typed,
                         sched_result_t res);
    dir_rows.push_back('{cmd, secs, prio, typed, res});
  endtask

  task automatic random_item();
    int pick;
    logic [15:0] secs;
    logic [7:0] prio;
    pick = $urandom_range(99);
    secs = ($urandom_range(49) == 0) ? 16'($urandom) : 16'($urandom_range(3));
    if ($urandom_range(9) == 0) prio = 8'($urandom);
    else prio = 8'($urandom_range(m_maxpri + 1, (m_minpri == 0) ? 0 : m_minpri - 1));
    if (pick < 25)      issue(pst_pkg::CMD_TICK, 16'($urandom), 8'($urandom), 0, '0);
    else if (pick < 45) issue(pst_pkg::CMD_CREATE, 16'($urandom), 8'($urandom), 0, '0);
    else if (pick < 60) issue(pst_pkg::CMD_SLEEP, secs, 8'($urandom), 0, '0);
    else if (pick < 75) issue(pst_pkg::CMD_SETPRI, 16'($urandom), prio, 0, '0);
    else if (pick < 85) issue(pst_pkg::CMD_TERM, 16'($urandom), 8'($urandom), 0, '0);
    else if (pick < 97) issue(pst_pkg::CMD_RESCHED, 16'($urandom), 8'($urandom), 0, '0);
    else issue(pick[0] ? CMD_SPARE6 : CMD_SPARE7, 16'($urandom), 8'($urandom), 0, '0);
  endtask

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    m_minpri = 8'd0;
    m_maxpri = 8'd15;
    m_tps = 16'd100;
    m_len[RDY] = 0;
    m_len[SLP] = 0;
    m_run = 0;
    m_present = 1'b0;
    m_pending = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      m_used[i] = 1'b0;
      m_pri[i] = '0;
      m_count[i] = '0;
    end

    add_row(pst_pkg::CMD_SLEEP, 16'd1, 8'd0, 1,
            '{pst_pkg::ST_NORUN, 4'd0, 1'b0, 4'd0, 1'b0, 1'b0, 5'd0});
    add_row(pst_pkg::CMD_SETPRI, 16'd0, 8'd5, 1,
            '{pst_pkg::ST_NORUN, 4'd0, 1'b0, 4'd0, 1'b0, 1'b0, 5'd0});
    add_row(pst_pkg::CMD_TERM, 16'd0, 8'd0, 1,
            '{pst_pkg::ST_NORUN, 4'd0, 1'b0, 4'd0, 1'b0, 1'b0, 5'd0});
    add_row(pst_pkg::CMD_TICK, 16'd0, 8'd0, 1,
            '{pst_pkg::ST_OK, 4'd0, 1'b0, 4'd0, 1'b0, 1'b0, 5'd0});
    add_row(pst_pkg::CMD_RESCHED, 16'd0, 8'd0, 1,
            '{pst_pkg::ST_OK, 4'd0, 1'b0, 4'd0, 1'b0, 1'b0, 5'd0});
    add_row(CMD_SPARE6, 16'hFFFF, 8'hFF, 1,
            '{pst_pkg::ST_OK, 4'd0, 1'b0, 4'd0, 1'b0, 1'b0, 5'd0});
    add_row(CMD_SPARE7, 16'd0, 8'd0, 1,
            '{pst_pkg::ST_OK, 4'd0, 1'b0, 4'd0, 1'b0, 1'b0, 5'd0});
    add_row(pst_pkg::CMD_CREATE, 16'd0, 8'd0, 1,
            '{pst_pkg::ST_OK, 4'd0, 1'b1, 4'd0, 1'b1, 1'b0, 5'd0});
    add_row(pst_pkg::CMD_CREATE, 16'd0, 8'd0, 1,
            '{pst_pkg::ST_OK, 4'd1, 1'b1, 4'd0, 1'b0, 1'b0, 5'd0});
    add_row(pst_pkg::CMD_SETPRI, 16'd0, 8'd16, 1,
            '{pst_pkg::ST_BADPRI, 4'd0, 1'b1, 4'd0, 1'b0, 1'b0, 5'd0});
    add_row(pst_pkg::CMD_SETPRI, 16'd0, 8'd15, 0, '0);
    add_row(pst_pkg::CMD_CREATE, 16'd0, 8'd0, 0, '0);
    add_row(pst_pkg::CMD_SETPRI, 16'd0, 8'd2, 0, '0);
    add_row(pst_pkg::CMD_RESCHED, 16'd0, 8'd0, 0, '0);
    add_row(pst_pkg::CMD_SLEEP, 16'd0, 8'd0, 0, '0);
    add_row(pst_pkg::CMD_SETPRI, 16'd0, 8'd0, 0, '0);
    add_row(pst_pkg::CMD_TICK, 16'd0, 8'd0, 0, '0);
    add_row(pst_pkg::CMD_RESCHED, 16'd0, 8'd0, 0, '0);
    add_row(pst_pkg::CMD_SLEEP, 16'hFFFF, 8'd0, 0, '0);
    add_row(pst_pkg::CMD_TERM, 16'd0, 8'd0, 0, '0);
    add_row(pst_pkg::CMD_TERM, 16'd0, 8'd0, 0, '0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i])
      issue(dir_rows[i].cmd, dir_rows[i].secs, dir_rows[i].prio, dir_rows[i].typed,
            dir_rows[i].res);
    repeat (SLOTS + 1) issue(pst_pkg::CMD_CREATE, 16'd0, 8'd0, 0, '0);
    repeat (SLOTS) issue(pst_pkg::CMD_TERM, 16'd0, 8'd0, 0, '0);

    write_reg(pst_pkg::REG_TPS, 16'hFFFF);
    write_reg(pst_pkg::REG_MINPRI, 16'd255);
    write_reg(pst_pkg::REG_MAXPRI, 16'd255);
    issue(pst_pkg::CMD_CREATE, 16'd0, 8'd0, 0, '0);
    issue(pst_pkg::CMD_SETPRI, 16'd0, 8'd255, 0, '0);
    issue(pst_pkg::CMD_SLEEP, 16'hFFFF, 8'd0, 0, '0);
    issue(pst_pkg::CMD_TICK, 16'd0, 8'd0, 0, '0);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          idle_pct = 34;
          write_reg(pst_pkg::REG_MINPRI, 16'd0);
          write_reg(pst_pkg::REG_MAXPRI, 16'd255);
          write_reg(pst_pkg::REG_TPS, 16'd1);
        end
        1: begin
          idle_pct = 46;
          write_reg(pst_pkg::REG_MINPRI, 16'd3);
          write_reg(pst_pkg::REG_MAXPRI, 16'd7);
          write_reg(pst_pkg::REG_TPS, 16'd2);
        end
        default: begin
          idle_pct = 0;
          write_reg(pst_pkg::REG_MINPRI, 16'd10);
          write_reg(pst_pkg::REG_MAXPRI, 16'd12);
          write_reg(pst_pkg::REG_TPS, 16'd1);
        end
      endcase
      repeat (330) random_item();
    end

    drain();
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
